### rtl/kpss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kpss_pkg;

  // Fixed field widths
  localparam int COORD_W      = 16;
  localparam int CFG_W        = 13;
  localparam int CENTER_INT_W = CFG_W - 1;  // integer bits of half the image size
  localparam int MODE_W       = 2;
  localparam int NUM_SLOTS    = 5;
  localparam int NUM_QUADS    = NUM_SLOTS - 1;
  localparam int QUEUE_DEPTH  = 2;

  localparam int ID_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF = 4;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_OFFER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DROP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam int CENTER_SLOT = 0;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_OFFER = 2'd1,
    OP_DROP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Quadrant q lives in slot q+1
  typedef enum logic [1:0] {
    QUAD_LR = 2'd0,
    QUAD_UR = 2'd1,
    QUAD_UL = 2'd2,
    QUAD_LL = 2'd3
  } quad_e;

  // Signed difference width: coordinate or centre, plus sign
  function automatic int diff_width(input int frac_bits);
    int w;
    w = CENTER_INT_W + frac_bits;
    if (w < COORD_W) begin
      w = COORD_W;
    end
    return w + 1;
  endfunction

endpackage
`default_nettype wire

### rtl/kpss_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module kpss_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = kpss_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign do_push = push_i && (cnt_q != CNT_W'(DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### rtl/kpss_front.sv
`timescale 1ns / 1ps
`default_nettype none
module kpss_front #(
  parameter int ID_WIDTH  = kpss_pkg::ID_WIDTH_DEF,
  parameter int FRAC_BITS = kpss_pkg::FRAC_BITS_DEF,
  parameter int ENTRY_W   = 8
) (
  input  wire logic [kpss_pkg::MODE_W-1:0]  mode_i,
  input  wire logic [ID_WIDTH-1:0]          feature_id_i,
  input  wire logic [kpss_pkg::COORD_W-1:0] pixel_x_i,
  input  wire logic [kpss_pkg::COORD_W-1:0] pixel_y_i,
  input  wire logic                         has_point_i,
  input  wire logic [kpss_pkg::CFG_W-1:0]   image_width_i,
  input  wire logic [kpss_pkg::CFG_W-1:0]   image_height_i,
  output logic [ENTRY_W-1:0]                entry_o
);

  localparam int DIFF_W  = kpss_pkg::diff_width(FRAC_BITS);
  localparam int SCORE_W = 2 * DIFF_W;

  logic [DIFF_W-1:0]         cx, cy, adx, ady, cheb;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic signed [SCORE_W-1:0] prod;
  kpss_pkg::op_e             op;
  kpss_pkg::quad_e           quad;

  always_comb begin
    cx   = DIFF_W'(image_width_i[kpss_pkg::CFG_W-1:1]) << FRAC_BITS;
    cy   = DIFF_W'(image_height_i[kpss_pkg::CFG_W-1:1]) << FRAC_BITS;
    dx   = $signed(DIFF_W'(pixel_x_i)) - $signed(cx);
    dy   = $signed(DIFF_W'(pixel_y_i)) - $signed(cy);
    adx  = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ady  = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    cheb = (adx > ady) ? adx : ady;
    prod = dx * dy;

    case (mode_i)
      kpss_pkg::MODE_OFFER: op = has_point_i ? kpss_pkg::OP_OFFER : kpss_pkg::OP_NONE;
      kpss_pkg::MODE_DROP:  op = kpss_pkg::OP_DROP;
      kpss_pkg::MODE_CLEAR: op = kpss_pkg::OP_CLEAR;
      default:              op = kpss_pkg::OP_NONE;
    endcase

    if (!dx[DIFF_W-1] && !dy[DIFF_W-1]) begin
      quad = kpss_pkg::QUAD_LR;
    end else if (!dx[DIFF_W-1]) begin
      quad = kpss_pkg::QUAD_UR;
    end else if (dy[DIFF_W-1]) begin
      quad = kpss_pkg::QUAD_UL;
    end else begin
      quad = kpss_pkg::QUAD_LL;
    end
  end

  // product is registered in the queue before the back end compares it
  assign entry_o = {op, feature_id_i, quad, cheb, prod};

endmodule
`default_nettype wire

### rtl/kpss_back.sv
`timescale 1ns / 1ps
`default_nettype none
module kpss_back #(
  parameter int ID_WIDTH  = kpss_pkg::ID_WIDTH_DEF,
  parameter int FRAC_BITS = kpss_pkg::FRAC_BITS_DEF,
  parameter int ENTRY_W   = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                head_valid_i,
  input  wire logic [ENTRY_W-1:0]  head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [kpss_pkg::NUM_SLOTS-1:0][ID_WIDTH-1:0] slot_id_o,
  output logic [kpss_pkg::NUM_SLOTS-1:0]               slot_occ_o
);

  localparam int DIFF_W  = kpss_pkg::diff_width(FRAC_BITS);
  localparam int SCORE_W = 2 * DIFF_W;
  localparam int NS      = kpss_pkg::NUM_SLOTS;
  localparam int NQ      = kpss_pkg::NUM_QUADS;

  kpss_pkg::op_e             h_op;
  logic [ID_WIDTH-1:0]       h_id;
  kpss_pkg::quad_e           h_quad;
  logic [DIFF_W-1:0]         h_dist;
  logic signed [SCORE_W-1:0] h_prod;

  logic [NS-1:0][ID_WIDTH-1:0] id_q, id_d;
  logic [NS-1:0]               occ_q, occ_d;
  logic [DIFF_W-1:0]           ctr_score_q, ctr_score_d;
  logic signed [SCORE_W-1:0]   quad_score_q [NQ];
  logic signed [SCORE_W-1:0]   quad_score_d [NQ];
  logic                        out_valid_q, out_valid_d;

  assign h_op   = kpss_pkg::op_e'(head_i[ENTRY_W-1 -: 2]);
  assign h_id   = head_i[ENTRY_W-3 -: ID_WIDTH];
  assign h_quad = kpss_pkg::quad_e'(head_i[SCORE_W+DIFF_W+1 -: 2]);
  assign h_dist = head_i[SCORE_W+DIFF_W-1 -: DIFF_W];
  assign h_prod = $signed(head_i[SCORE_W-1:0]);

  // Slots only change on a pop, and a pop always loads the result, so the
  // slot registers themselves form the output register.
  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    id_d        = id_q;
    occ_d       = occ_q;
    ctr_score_d = ctr_score_q;
    for (int q = 0; q < NQ; q++) begin
      quad_score_d[q] = quad_score_q[q];
    end
    if (pop_o) begin
      case (h_op)
        kpss_pkg::OP_OFFER: begin
          if (!occ_q[kpss_pkg::CENTER_SLOT] || (h_dist < ctr_score_q)) begin
            occ_d[kpss_pkg::CENTER_SLOT] = 1'b1;
            id_d[kpss_pkg::CENTER_SLOT]  = h_id;
            ctr_score_d                  = h_dist;
          end
          for (int q = 0; q < NQ; q++) begin
            if ((h_quad == kpss_pkg::quad_e'(q)) &&
                (!occ_q[q+1] || (h_prod > quad_score_q[q]))) begin
              occ_d[q+1]      = 1'b1;
              id_d[q+1]       = h_id;
              quad_score_d[q] = h_prod;
            end
          end
        end
        kpss_pkg::OP_DROP: begin
          for (int s = 0; s < NS; s++) begin
            if (occ_q[s] && (id_q[s] == h_id)) begin
              occ_d[s] = 1'b0;
              id_d[s]  = '0;
            end
          end
        end
        kpss_pkg::OP_CLEAR: begin
          occ_d = '0;
          id_d  = '0;
        end
        default: begin
        end
      endcase
    end

    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q        <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      id_q        <= id_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // scores are only read for occupied slots
  always_ff @(posedge clk_i) begin
    ctr_score_q <= ctr_score_d;
    for (int q = 0; q < NQ; q++) begin
      quad_score_q[q] <= quad_score_d[q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_id_o   = id_q;
  assign slot_occ_o  = occ_q;

endmodule
`default_nettype wire

### rtl/key_point_slot_selector.sv
// An accepted item is registered in the queue, then in the slot registers.
// Throughput: one item per cycle unless stalled. The front end computes offsets and
// product; a two-entry queue decouples it from the slot update, which can stall too.
// Reset (rst_ni, asynchronous, active low) empties all slots and the queue and sets
// image_width to 640 and image_height to 480. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module key_point_slot_selector #(
  parameter int ID_WIDTH  = kpss_pkg::ID_WIDTH_DEF,
  parameter int FRAC_BITS = kpss_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [kpss_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [kpss_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [kpss_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  // item input
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [kpss_pkg::MODE_W-1:0]      mode_i,
  input  wire logic [ID_WIDTH-1:0]              feature_id_i,
  input  wire logic [kpss_pkg::COORD_W-1:0]     pixel_x_i,
  input  wire logic [kpss_pkg::COORD_W-1:0]     pixel_y_i,
  input  wire logic                             has_point_i,
  // result output
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [ID_WIDTH-1:0]                   center_slot_id_o,
  output logic [ID_WIDTH-1:0]                   lower_right_slot_id_o,
  output logic [ID_WIDTH-1:0]                   upper_right_slot_id_o,
  output logic [ID_WIDTH-1:0]                   upper_left_slot_id_o,
  output logic [ID_WIDTH-1:0]                   lower_left_slot_id_o,
  output logic [kpss_pkg::NUM_SLOTS-1:0]        slot_valid_mask_o
);

  localparam int DIFF_W  = kpss_pkg::diff_width(FRAC_BITS);
  localparam int SCORE_W = 2 * DIFF_W;
  // queue entry: op, id, quadrant, Chebyshev distance, quadrant product
  localparam int ENTRY_W = 2 + ID_WIDTH + 2 + DIFF_W + SCORE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers; only paddr[2] selects, low address bits ignored.
  // ---------------------------------------------------------------------------
  logic [kpss_pkg::CFG_W-1:0] img_w_q, img_h_q;
  logic                       cfg_wr;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= kpss_pkg::IMAGE_WIDTH_RST;
      img_h_q <= kpss_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_wr) begin
      if (reg_sel == kpss_pkg::REG_IMAGE_WIDTH) begin
        img_w_q <= pwdata[kpss_pkg::CFG_W-1:0];
      end else begin
        img_h_q <= pwdata[kpss_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == kpss_pkg::REG_IMAGE_HEIGHT) begin
      prdata = kpss_pkg::APB_DATA_W'(img_h_q);
    end else begin
      prdata = kpss_pkg::APB_DATA_W'(img_w_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: classify the item, work out distance, quadrant and product.
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] push_entry, head_entry;
  logic               q_full, q_valid, q_pop, q_push;

  kpss_front #(
    .ID_WIDTH  (ID_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .mode_i         (mode_i),
    .feature_id_i   (feature_id_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .has_point_i    (has_point_i),
    .image_width_i  (img_w_q),
    .image_height_i (img_h_q),
    .entry_o        (push_entry)
  );

  // stall is a register output, never combinational from the far side
  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  kpss_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (kpss_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_entry)
  );

  // ---------------------------------------------------------------------------
  // Back end: slot update; the slot registers drive the result ports.
  // ---------------------------------------------------------------------------
  logic [kpss_pkg::NUM_SLOTS-1:0][ID_WIDTH-1:0] slot_id;

  kpss_back #(
    .ID_WIDTH  (ID_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_entry),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .slot_id_o    (slot_id),
    .slot_occ_o   (slot_valid_mask_o)
  );

  // empty slots hold id zero, so no masking is needed here
  assign center_slot_id_o      = slot_id[0];
  assign lower_right_slot_id_o = slot_id[1];
  assign upper_right_slot_id_o = slot_id[2];
  assign upper_left_slot_id_o  = slot_id[3];
  assign lower_left_slot_id_o  = slot_id[4];

endmodule
`default_nettype wire

### rtl/kpss_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module kpss_checker #(
  parameter int ID_WIDTH = kpss_pkg::ID_WIDTH_DEF
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic [ID_WIDTH-1:0]       center_slot_id_o,
  input wire logic [ID_WIDTH-1:0]       lower_right_slot_id_o,
  input wire logic [ID_WIDTH-1:0]       upper_right_slot_id_o,
  input wire logic [ID_WIDTH-1:0]       upper_left_slot_id_o,
  input wire logic [ID_WIDTH-1:0]       lower_left_slot_id_o,
  input wire logic [kpss_pkg::NUM_SLOTS-1:0] slot_valid_mask_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_valid_mask_o)
      && $stable(center_slot_id_o) && $stable(lower_left_slot_id_o))
    else $error("result changed while stalled");

  // a fresh result needs an item that was taken and passed through the queue
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without an item");

  // empty slots report id zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (slot_valid_mask_o[0] || center_slot_id_o == '0) &&
      (slot_valid_mask_o[1] || lower_right_slot_id_o == '0) &&
      (slot_valid_mask_o[2] || upper_right_slot_id_o == '0) &&
      (slot_valid_mask_o[3] || upper_left_slot_id_o == '0) &&
      (slot_valid_mask_o[4] || lower_left_slot_id_o == '0))
    else $error("empty slot with non-zero id");

  // nothing is reported in the cycle after reset is released
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("handshake active straight out of reset");

endmodule

bind key_point_slot_selector kpss_checker #(.ID_WIDTH(ID_WIDTH)) u_kpss_checker (.*);
`default_nettype wire

### tb/key_point_slot_selector_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the key-point slot selector.
// Items go in on a valid/stall channel, one slot report comes back per item.
// A slot model predicts untyped reports; both channels idle at random unless quiet.
module key_point_slot_selector_tb;
  import kpss_pkg::*;

  localparam int ID_W = ID_WIDTH_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;   // cycles with no item moving on either side
  localparam int PHASE_ITEMS = 155;

  // the spare mode value, which the block must ignore
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // register byte addresses: index times four
  localparam logic [APB_ADDR_W-1:0] ADDR_IMAGE_WIDTH  = {REG_IMAGE_WIDTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_IMAGE_HEIGHT = {REG_IMAGE_HEIGHT, 2'b00};

  // one slot report: ids in slot order (centre first), then the occupancy mask
  typedef struct packed {
    logic [0:NUM_SLOTS-1][ID_W-1:0] id;
    logic [NUM_SLOTS-1:0]           mask;
  } slot_report_t;

  // one row of stimulus; typed rows carry their report written out by hand
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               has_point;
    logic               typed;
    slot_report_t       want;
  } stim_item_t;

  localparam slot_report_t NO_SLOTS = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [MODE_W-1:0]  mode_i = MODE_OFFER;
  logic [ID_W-1:0]    feature_id_i = '0;
  logic [COORD_W-1:0] pixel_x_i = '0;
  logic [COORD_W-1:0] pixel_y_i = '0;
  logic               has_point_i = 1'b0;

  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [ID_W-1:0]    center_slot_id_o;
  logic [ID_W-1:0]    lower_right_slot_id_o;
  logic [ID_W-1:0]    upper_right_slot_id_o;
  logic [ID_W-1:0]    upper_left_slot_id_o;
  logic [ID_W-1:0]    lower_left_slot_id_o;
  logic [NUM_SLOTS-1:0] slot_valid_mask_o;

  // typed expectation travelling alongside the item on the wire
  logic         cur_typed = 1'b0;
  slot_report_t cur_want = '0;

  key_point_slot_selector dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .mode_i                (mode_i),
    .feature_id_i          (feature_id_i),
    .pixel_x_i             (pixel_x_i),
    .pixel_y_i             (pixel_y_i),
    .has_point_i           (has_point_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .center_slot_id_o      (center_slot_id_o),
    .lower_right_slot_id_o (lower_right_slot_id_o),
    .upper_right_slot_id_o (upper_right_slot_id_o),
    .upper_left_slot_id_o  (upper_left_slot_id_o),
    .lower_left_slot_id_o  (lower_left_slot_id_o),
    .slot_valid_mask_o     (slot_valid_mask_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Slot model: own copy of the size registers and of the five slots
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] size_x = IMAGE_WIDTH_RST;
  logic [CFG_W-1:0] size_y = IMAGE_HEIGHT_RST;
  logic [ID_W-1:0]  held_id [NUM_SLOTS] = '{default: '0};
  logic             held    [NUM_SLOTS] = '{default: 1'b0};
  longint           held_score [NUM_SLOTS];   // meaningful only while held

  slot_report_t slot_reports_due [$];

  int error_count = 0;
  int items_sent = 0;
  int reports_checked = 0;
  int size_settings = 0;
  bit quiet = 1'b0;       // set for stretches with no idling on either side
  int stall_run = 0;
  int idle_cycles = 0;
  logic [ID_W-1:0] id_pool [8];

  string slot_name [NUM_SLOTS] =
    '{"centre", "lower right", "upper right", "upper left", "lower left"};

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  // strict improvement only; an empty slot takes anything
  function automatic void try_slot(input int s, input logic [ID_W-1:0] id,
                                   input longint score, input bit lower_wins);
    bit take;
    if (!held[s]) take = 1'b1;
    else if (lower_wins) take = score < held_score[s];
    else take = score > held_score[s];
    if (take) begin
      held[s] = 1'b1;
      held_id[s] = id;
      held_score[s] = score;
    end
  endfunction

  function automatic slot_report_t update_slots(input logic [MODE_W-1:0] mode,
                                                input logic [ID_W-1:0] id,
                                                input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic has_point);
    longint cx, cy, dx, dy, adx, ady;
    quad_e q;
    slot_report_t r;
    cx = longint'(size_x >> 1) << FRAC;
    cy = longint'(size_y >> 1) << FRAC;
    if (mode == MODE_OFFER && has_point) begin
      dx = longint'(x) - cx;
      dy = longint'(y) - cy;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      try_slot(CENTER_SLOT, id, adx > ady ? adx : ady, 1'b1);
      // x at the centre counts as right, y at the centre as lower
      if (dx >= 0 && dy >= 0) q = QUAD_LR;
      else if (dx >= 0) q = QUAD_UR;
      else if (dy < 0) q = QUAD_UL;
      else q = QUAD_LL;
      try_slot(int'(q) + 1, id, dx * dy, 1'b0);
    end else if (mode == MODE_DROP) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (held[s] && held_id[s] == id) begin
          held[s] = 1'b0;
          held_id[s] = '0;
        end
      end
    end else if (mode == MODE_CLEAR) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        held[s] = 1'b0;
        held_id[s] = '0;
      end
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      r.id[s] = held[s] ? held_id[s] : '0;
      r.mask[s] = held[s];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything is judged at the rising edge, on pre-edge values
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    slot_report_t got, want, predicted;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_IMAGE_WIDTH) size_x = pwdata[CFG_W-1:0];
        else if (paddr == ADDR_IMAGE_HEIGHT) size_y = pwdata[CFG_W-1:0];
      end
      if (in_valid_i && !in_stall_o) begin
        // model always advances; a typed row overrides what gets compared
        predicted = update_slots(mode_i, feature_id_i, pixel_x_i, pixel_y_i, has_point_i);
        slot_reports_due.insert(slot_reports_due.size(), cur_typed ? cur_want : predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        got.id = {center_slot_id_o, lower_right_slot_id_o, upper_right_slot_id_o,
                  upper_left_slot_id_o, lower_left_slot_id_o};
        got.mask = slot_valid_mask_o;
        if (slot_reports_due.size() == 0) begin
          flag_mismatch("result with nothing outstanding", 32'(got.mask), 32'h0);
        end else begin
          want = slot_reports_due.pop_front();
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (got.id[s] !== want.id[s])
              flag_mismatch({slot_name[s], " slot id"}, 32'(got.id[s]), 32'(want.id[s]));
          end
          if (got.mask !== want.mask)
            flag_mismatch("slot valid mask", 32'(got.mask), 32'(want.mask));
          reports_checked++;
        end
      end
    end
  end

  // watchdog: counts cycles in which no item moves on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no item moved for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver back-pressure: runs of stall, mostly short, now and then long
  always @(negedge clk_i) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: inputs move on the falling edge
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // present one item, hold it until the block takes it
  task automatic send_item(input stim_item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= it.mode;
    feature_id_i <= it.id;
    pixel_x_i    <= it.x;
    pixel_y_i    <= it.y;
    has_point_i  <= it.has_point;
    cur_typed    <= it.typed;
    cur_want     <= it.want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // drop valid and let every outstanding report drain before touching registers
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (slot_reports_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== 32'(want)) flag_mismatch("register read back", prdata, 32'(want));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // coordinate generator: clusters round the centre, spread over the image,
  // or anywhere in the 16-bit range
  function automatic logic [COORD_W-1:0] pick_coord(input int centre);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = centre + int'($urandom_range(0, 64)) - 32;
      3, 4, 5, 6, 7: v = int'($urandom_range(0, centre * 2 + 16));
      default: v = int'($urandom_range(0, 65535));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return COORD_W'(v);
  endfunction

  // Random items. Ids come mostly from a small pool so that drops and
  // repeated offers hit slots that are actually held; clears now and then
  // empty the frame so the slots keep refilling.
  task automatic run_random(input int count);
    stim_item_t it;
    int r, cx, cy;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) id_pool[$urandom_range(0, 7)] = ID_W'($urandom);
      cx = int'(size_x >> 1) << FRAC;
      cy = int'(size_y >> 1) << FRAC;
      it = '0;
      it.id = ($urandom_range(0, 4) != 0) ? id_pool[$urandom_range(0, 7)] : ID_W'($urandom);
      it.x = pick_coord(cx);
      it.y = pick_coord(cy);
      r = $urandom_range(0, 99);
      if (r < 72) begin
        it.mode = MODE_OFFER;
        it.has_point = 1'b1;
      end else if (r < 78) begin
        it.mode = MODE_OFFER;
        it.has_point = 1'b0;
      end else if (r < 91) begin
        it.mode = MODE_DROP;
        it.has_point = 1'($urandom);
      end else if (r < 96) begin
        it.mode = MODE_CLEAR;
        it.has_point = 1'($urandom);
      end else begin
        it.mode = MODE_SPARE;
        it.has_point = 1'($urandom);
      end
      send_item(it);
    end
    quiet = 1'b0;
  endtask

  // new image size, written only once the block has gone quiet; the slots
  // stay as they are, so old scores meet offers judged against the new centre
  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int count);
    drain();
    cfg_write(ADDR_IMAGE_WIDTH, w);
    cfg_write(ADDR_IMAGE_HEIGHT, h);
    cfg_read(ADDR_IMAGE_WIDTH, w);
    cfg_read(ADDR_IMAGE_HEIGHT, h);
    size_settings++;
    run_random(count);
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows, at the reset size 640 x 480: centre (0x1400, 0x0F00)
  // ---------------------------------------------------------------------------
  stim_item_t directed_tab [0:20] = '{
    // offer without a 3D point: nothing taken
    '{MODE_OFFER, 16'h1111, 16'h0000, 16'h0000, 1'b0, 1'b1, NO_SLOTS},
    // spare mode, all fields at their top: ignored
    '{MODE_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, NO_SLOTS},
    // drop of id 0 while every slot is empty must not match the zeroed ids
    '{MODE_DROP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, NO_SLOTS},
    // first offer, top-left corner: centre and upper left
    '{MODE_OFFER, 16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b1,
      '{'{16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0000}, 5'b01001}},
    // bottom-right corner: lower right only
    '{MODE_OFFER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
      '{'{16'h0001, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000}, 5'b01011}},
    // exactly on the centre: wins the centre slot, product 0 loses lower right
    '{MODE_OFFER, 16'h00AA, 16'h1400, 16'h0F00, 1'b1, 1'b1,
      '{'{16'h00AA, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000}, 5'b01011}},
    '{MODE_OFFER, 16'h5555, 16'hFFFF, 16'h0000, 1'b1, 1'b1,
      '{'{16'h00AA, 16'hFFFF, 16'h5555, 16'h0001, 16'h0000}, 5'b01111}},
    '{MODE_OFFER, 16'h2222, 16'h0000, 16'hFFFF, 1'b1, 1'b1,
      '{'{16'h00AA, 16'hFFFF, 16'h5555, 16'h0001, 16'h2222}, 5'b11111}},
    // ties must not replace: centre again, then the same upper-left corner
    '{MODE_OFFER, 16'h0BBB, 16'h1400, 16'h0F00, 1'b1, 1'b0, NO_SLOTS},
    '{MODE_OFFER, 16'h3333, 16'h0000, 16'h0000, 1'b1, 1'b0, NO_SLOTS},
    // on the vertical centre line, just above: upper right with product 0
    '{MODE_OFFER, 16'h4444, 16'h1400, 16'h0EFF, 1'b1, 1'b0, NO_SLOTS},
    // just left of centre on the horizontal line: lower left with product 0
    '{MODE_OFFER, 16'h6666, 16'h13FF, 16'h0F00, 1'b1, 1'b0, NO_SLOTS},
    '{MODE_OFFER, 16'h7777, 16'h1401, 16'h0F01, 1'b0, 1'b0, NO_SLOTS},
    '{MODE_DROP, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b0, NO_SLOTS},
    '{MODE_DROP, 16'h1234, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, NO_SLOTS},
    // id 0 held in a slot, then dropped
    '{MODE_OFFER, 16'h0000, 16'h1401, 16'h0F01, 1'b1, 1'b0, NO_SLOTS},
    '{MODE_DROP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, NO_SLOTS},
    // clear ignores its payload
    '{MODE_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, NO_SLOTS},
    // one id in two slots, dropped from both at once
    '{MODE_OFFER, 16'h8888, 16'h1000, 16'h1000, 1'b1, 1'b0, NO_SLOTS},
    '{MODE_DROP, 16'h8888, 16'h0000, 16'h0000, 1'b0, 1'b1, NO_SLOTS},
    '{MODE_SPARE, 16'h5A5A, 16'h0000, 16'h0000, 1'b0, 1'b1, NO_SLOTS}
  };

  initial begin
    for (int i = 0; i < 8; i++) id_pool[i] = ID_W'($urandom);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values must read back before anything is written
    cfg_read(ADDR_IMAGE_WIDTH, IMAGE_WIDTH_RST);
    cfg_read(ADDR_IMAGE_HEIGHT, IMAGE_HEIGHT_RST);

    for (int i = 0; i < $size(directed_tab); i++) send_item(directed_tab[i]);

    // smallest, largest, odd, lopsided and random sizes, then back to reset
    run_phase(13'd2, 13'd2, PHASE_ITEMS);
    run_phase(13'd4096, 13'd4096, PHASE_ITEMS);
    run_phase(13'd3, 13'd4095, PHASE_ITEMS);
    run_phase(13'd4096, 13'd2, PHASE_ITEMS);
    run_phase(13'($urandom_range(2, 4096)), 13'($urandom_range(2, 4096)), PHASE_ITEMS);
    run_phase(13'd2, 13'd4096, PHASE_ITEMS);
    run_phase(IMAGE_WIDTH_RST, IMAGE_HEIGHT_RST, PHASE_ITEMS);

    drain();
    repeat (5) @(posedge clk_i);

    $display("Sent %0d items (offers, drops, clears, spare mode) over %0d image sizes;",
             items_sent, size_settings + 1);
    $display("checked %0d slot reports, %0d mismatches.", reports_checked, error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
